// ===== rtl/core/gtd_pkg.sv =====
package gtd_pkg;

	localparam int MaxBlock   = 4096;
	localparam int NumBins    = 3;
	localparam int MinBlock   = 8;
	localparam int CntW       = 13;
	localparam int StateW     = 48;
	localparam int MagW       = 40;
	localparam int SampleW    = 16;
	localparam int CfgIdxW    = 4;
	localparam int CfgDataW   = 16;
	localparam int RootSteps  = 41;
	localparam int AccW       = 2 * RootSteps;

	localparam logic [CfgIdxW-1:0] REG_BLOCK_SIZE = 4'd0;
	localparam logic [CfgIdxW-1:0] REG_BIN_COUNT  = 4'd1;
	localparam logic [CfgIdxW-1:0] REG_COS_FIRST  = 4'd2;
	localparam logic [CfgIdxW-1:0] REG_SIN_FIRST  = 4'd3;
	localparam logic [CfgIdxW-1:0] REG_COS_SECOND = 4'd4;
	localparam logic [CfgIdxW-1:0] REG_SIN_SECOND = 4'd5;
	localparam logic [CfgIdxW-1:0] REG_COS_THIRD  = 4'd6;
	localparam logic [CfgIdxW-1:0] REG_SIN_THIRD  = 4'd7;

	localparam logic [MagW-1:0] MAG_MAX = {MagW{1'b1}};

	typedef struct packed {
		logic [CntW-1:0]           block_size;
		logic [1:0]                bin_count;
		logic [NumBins-1:0][15:0]  coef_cos;
		logic [NumBins-1:0][14:0]  coef_sin;
	} cfg_t;

	// One queued request: the sample, its block-end mark and whether it
	// still falls within the block limit.
	typedef struct packed {
		logic signed [SampleW-1:0] sample;
		logic                      last;
		logic                      counted;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_head_t;

endpackage

// ===== rtl/core/goertzel_tone_detector_core.sv =====
// Goertzel tone detector for up to three target bins.
// Samples arrive on the input channel (in_valid/in_ready) as a signed
// 16-bit value with an end_of_block mark. Results leave on the output
// channel (out_valid/out_ready): one magnitude per enabled bin, in bin
// order, with last_bin set on the final one of a block.
// Registers are written through cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high. Write them only while idle.
// A sample that enters the recursion is picked up from the queue and
// then updates each of the three bins in turn on the shared multiplier;
// a sample beyond the block limit is only picked up. At a block end each
// enabled bin goes through the cross products, the squares on one 20x20
// multiplier, the bit-serial square root and the load of the output
// register.
// A two-entry queue sits between the input side and the back end, so
// samples keep flowing in while the back end works or while the output
// register holds a result that the receiver has not yet taken. When the
// receiver stalls, the back end waits with its next result and the queue
// fills, then in_ready drops.
// Reset clears the recursion state, the counters and the registers to
// their defaults (block size 256, no bins enabled, coefficients zero).
module goertzel_tone_detector_core import gtd_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [SampleW-1:0] sample,
	input  logic                      end_of_block,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                bin_index,
	output logic [MagW-1:0]           magnitude,
	output logic                      last_bin,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CfgIdxW-1:0]        cfg_index,
	input  logic [CfgDataW-1:0]       cfg_data
);

	cfg_t        cfg_q;
	logic        push_valid;
	logic        push_ready;
	item_t       push_item;
	logic        pop;
	queue_head_t head;

	assign cfg_ready = 1'b1;

	// Register file. Indices past the last register are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.block_size <= CntW'(256);
			cfg_q.bin_count  <= '0;
			cfg_q.coef_cos   <= '0;
			cfg_q.coef_sin   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BLOCK_SIZE: cfg_q.block_size  <= cfg_data[CntW-1:0];
				REG_BIN_COUNT:  cfg_q.bin_count   <= cfg_data[1:0];
				REG_COS_FIRST:  cfg_q.coef_cos[0] <= cfg_data;
				REG_SIN_FIRST:  cfg_q.coef_sin[0] <= cfg_data[14:0];
				REG_COS_SECOND: cfg_q.coef_cos[1] <= cfg_data;
				REG_SIN_SECOND: cfg_q.coef_sin[1] <= cfg_data[14:0];
				REG_COS_THIRD:  cfg_q.coef_cos[2] <= cfg_data;
				REG_SIN_THIRD:  cfg_q.coef_sin[2] <= cfg_data[14:0];
				default: begin
				end
			endcase
		end
	end

	// The front end tags each request with whether it is still inside
	// the block limit.
	gtd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample       (sample),
		.end_of_block (end_of_block),
		.block_size   (cfg_q.block_size),
		.push_ready   (push_ready),
		.push_valid   (push_valid),
		.push_item    (push_item)
	);

	gtd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop        (pop),
		.head       (head)
	);

	// The back end runs the recursion and, at a block end, the
	// magnitude sequence for each enabled bin.
	gtd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.bin_index (bin_index),
		.magnitude (magnitude),
		.last_bin  (last_bin)
	);

endmodule

// ===== rtl/core/gtd_front.sv =====
module gtd_front import gtd_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [SampleW-1:0] sample,
	input  logic                      end_of_block,
	input  logic [CntW-1:0]           block_size,
	input  logic                      push_ready,
	output logic                      push_valid,
	output item_t                     push_item
);

	logic [CntW-1:0] count_q;
	logic [CntW-1:0] limit;
	logic            accept;

	always_comb begin
		if (block_size < CntW'(MinBlock)) begin
			limit = CntW'(MinBlock);
		end else if (block_size > CntW'(MaxBlock)) begin
			limit = CntW'(MaxBlock);
		end else begin
			limit = block_size;
		end
	end

	assign in_ready          = push_ready;
	assign push_valid        = in_valid;
	assign accept            = in_valid && push_ready;
	assign push_item.sample  = sample;
	assign push_item.last    = end_of_block;
	assign push_item.counted = count_q < limit;

	// The count restarts with the request that follows a block end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (end_of_block) begin
				count_q <= '0;
			end else if (count_q < limit) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/gtd_queue.sv =====
module gtd_queue import gtd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push_valid,
	output logic        push_ready,
	input  item_t       push_item,
	input  logic        pop,
	output queue_head_t head
);

	item_t      entry_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] fill_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = fill_q != 2'd2;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && (fill_q != 2'd0);
	assign head.valid = fill_q != 2'd0;
	assign head.item  = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			fill_q <= fill_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

// ===== rtl/core/gtd_back.sv =====
module gtd_back import gtd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  queue_head_t       head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        bin_index,
	output logic [MagW-1:0]   magnitude,
	output logic              last_bin
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_UPD  = 6'b000010,
		S_PROD = 6'b000100,
		S_RI   = 6'b001000,
		S_SQ   = 6'b010000,
		S_ROOT = 6'b100000
	} state_t;

	state_t state_q;
	logic   emit_q;

	logic signed [StateW-1:0] s1_q [NumBins];
	logic signed [StateW-1:0] s2_q [NumBins];
	logic signed [SampleW-1:0] x_q;
	logic                      last_q;
	logic [1:0]                bin_q;

	logic signed [63:0] pc_s1;
	logic signed [63:0] ps_s1;
	logic signed [StateW-1:0] s1_s1;

	logic [MagW-1:0]  are_q;
	logic [MagW-1:0]  aim_q;
	logic [2:0]       step_q;
	logic [AccW-1:0]  acc_q;
	logic [RootSteps-1:0] root_q;
	logic [RootSteps+1:0] rem_q;
	logic [5:0]       root_cnt_q;
	logic [MagW-1:0]  mag_q;

	logic             out_valid_q;
	logic [1:0]       out_bin_q;
	logic [MagW-1:0]  out_mag_q;
	logic             out_last_q;

	logic signed [15:0]       cos_sel;
	logic signed [15:0]       sin_ext;
	logic signed [StateW-1:0] s1_sel;
	logic signed [StateW-1:0] s2_sel;
	logic signed [63:0]       upd_prod;
	logic signed [49:0]       upd_t;
	logic signed [51:0]       upd_sum;
	logic signed [StateW-1:0] upd_sat;
	logic signed [49:0]       re_v;
	logic signed [49:0]       im_v;
	logic [49:0]              are_v;
	logic [49:0]              aim_v;
	logic [MagW-1:0]          sq_op;
	logic [19:0]              sq_a;
	logic [19:0]              sq_b;
	logic [39:0]              sq_p;
	logic [AccW-1:0]          sq_term;
	logic [RootSteps+1:0]     rem_sh;
	logic [RootSteps+1:0]     trial;
	logic [1:0]               enabled;
	logic                     out_free;
	logic                     final_bin;

	assign enabled   = cfg.bin_count;
	assign cos_sel   = $signed(cfg.coef_cos[bin_q]);
	assign sin_ext   = $signed({1'b0, cfg.coef_sin[bin_q]});
	assign s1_sel    = s1_q[bin_q];
	assign s2_sel    = s2_q[bin_q];
	assign out_free  = !out_valid_q || out_ready;
	assign final_bin = (bin_q + 2'd1) == enabled;
	assign pop       = (state_q == S_IDLE) && !emit_q && head.valid;

	// Recursion step for one bin.
	always_comb begin
		upd_prod = 64'(cos_sel) * 64'(s1_sel);
		upd_t    = 50'((upd_prod + 64'sd4096) >>> 13);
		upd_sum  = 52'(x_q) + 52'(upd_t) - 52'(s2_sel);
		if (upd_sum > 52'sh7FFF_FFFF_FFFF) begin
			upd_sat = {1'b0, {(StateW-1){1'b1}}};
		end else if (upd_sum < -52'sh8000_0000_0000) begin
			upd_sat = {1'b1, {(StateW-1){1'b0}}};
		end else begin
			upd_sat = upd_sum[StateW-1:0];
		end
	end

	// Real and imaginary parts from the registered products.
	always_comb begin
		re_v  = 50'(s1_s1) - 50'((pc_s1 + 64'sd8192) >>> 14);
		im_v  = 50'((ps_s1 + 64'sd8192) >>> 14);
		are_v = re_v[49] ? 50'(-re_v) : 50'(re_v);
		aim_v = im_v[49] ? 50'(-im_v) : 50'(im_v);
	end

	// Squares from 20-bit halves: high*high, high*low doubled by the shift, low*low.
	always_comb begin
		sq_op = step_q[2] ? aim_q : are_q;
		if (step_q[2]) begin
			sq_op = aim_q;
		end
		case (step_q[1:0])
			2'd0: begin
				sq_a = sq_op[39:20];
				sq_b = sq_op[39:20];
			end
			2'd1: begin
				sq_a = sq_op[39:20];
				sq_b = sq_op[19:0];
			end
			default: begin
				sq_a = sq_op[19:0];
				sq_b = sq_op[19:0];
			end
		endcase
		sq_p = 40'(sq_a) * 40'(sq_b);
		case (step_q[1:0])
			2'd0:    sq_term = AccW'(sq_p) << 40;
			2'd1:    sq_term = AccW'(sq_p) << 21;
			default: sq_term = AccW'(sq_p);
		endcase
	end

	// One result bit of the square root per cycle.
	always_comb begin
		rem_sh = {rem_q[RootSteps-1:0], acc_q[AccW-1 -: 2]};
		trial  = {root_q, 2'b01};
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			x_q    <= head.item.sample;
			last_q <= head.item.last;
		end
		pc_s1 <= 64'(s2_sel) * 64'(cos_sel);
		ps_s1 <= 64'(s2_sel) * 64'(sin_ext);
		s1_s1 <= s1_sel;
		if (state_q == S_RI) begin
			are_q <= are_v[MagW-1:0];
			aim_q <= aim_v[MagW-1:0];
		end
		if (emit_q && out_free) begin
			out_bin_q  <= bin_q;
			out_mag_q  <= mag_q;
			out_last_q <= final_bin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			emit_q      <= 1'b0;
			bin_q       <= '0;
			step_q      <= '0;
			acc_q       <= '0;
			root_q      <= '0;
			rem_q       <= '0;
			root_cnt_q  <= '0;
			mag_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NumBins; i++) begin
				s1_q[i] <= '0;
				s2_q[i] <= '0;
			end
		end else begin
			// A held result stays until taken; a new one loads when the
			// register is free.
			out_valid_q <= (out_valid_q && !out_ready) ||
				((state_q == S_IDLE) && emit_q && out_free);
			case (state_q)
				S_IDLE: begin
					if (emit_q) begin
						if (out_free) begin
							emit_q <= 1'b0;
							if (final_bin) begin
								bin_q <= '0;
								for (int i = 0; i < NumBins; i++) begin
									s1_q[i] <= '0;
									s2_q[i] <= '0;
								end
							end else begin
								bin_q   <= bin_q + 2'd1;
								state_q <= S_PROD;
							end
						end
					end else if (pop) begin
						bin_q <= '0;
						if (head.item.counted) begin
							state_q <= S_UPD;
						end else if (head.item.last) begin
							if (enabled == 2'd0) begin
								for (int i = 0; i < NumBins; i++) begin
									s1_q[i] <= '0;
									s2_q[i] <= '0;
								end
							end else begin
								state_q <= S_PROD;
							end
						end
					end
				end
				S_UPD: begin
					if (bin_q == 2'(NumBins - 1)) begin
						bin_q <= '0;
						if (last_q && (enabled == 2'd0)) begin
							state_q <= S_IDLE;
							for (int i = 0; i < NumBins; i++) begin
								s1_q[i] <= '0;
								s2_q[i] <= '0;
							end
						end else begin
							s2_q[bin_q] <= s1_sel;
							s1_q[bin_q] <= upd_sat;
							if (last_q) begin
								state_q <= S_PROD;
							end else begin
								state_q <= S_IDLE;
							end
						end
					end else begin
						s2_q[bin_q] <= s1_sel;
						s1_q[bin_q] <= upd_sat;
						bin_q       <= bin_q + 2'd1;
					end
				end
				S_PROD: begin
					state_q <= S_RI;
				end
				S_RI: begin
					if ((are_v > 50'(MAG_MAX)) || (aim_v > 50'(MAG_MAX))) begin
						mag_q   <= MAG_MAX;
						emit_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						step_q  <= '0;
						acc_q   <= '0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					acc_q <= acc_q + sq_term;
					if (step_q == 3'd6) begin
						root_q     <= '0;
						rem_q      <= '0;
						root_cnt_q <= '0;
						state_q    <= S_ROOT;
					end else if (step_q[1:0] == 2'd2) begin
						step_q <= 3'd4;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				S_ROOT: begin
					if (root_cnt_q == 6'(RootSteps)) begin
						mag_q   <= root_q[RootSteps-1] ? MAG_MAX : root_q[MagW-1:0];
						emit_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						acc_q <= acc_q << 2;
						if (rem_sh >= trial) begin
							rem_q  <= rem_sh - trial;
							root_q <= {root_q[RootSteps-2:0], 1'b1};
						end else begin
							rem_q  <= rem_sh;
							root_q <= {root_q[RootSteps-2:0], 1'b0};
						end
						root_cnt_q <= root_cnt_q + 6'd1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign bin_index = out_bin_q;
	assign magnitude = out_mag_q;
	assign last_bin  = out_last_q;

	// The queue is only drained between requests.
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == S_IDLE) && !emit_q)
		else $error("queue pop while a request is in progress");

	assert property (@(posedge clk) disable iff (!arst_n)
		bin_q != 2'd3)
		else $error("bin counter out of range");

	// A held result is never overwritten before it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(magnitude))
		else $error("pending result was overwritten");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROOT) |-> root_cnt_q <= 6'(RootSteps))
		else $error("square root ran past its step count");

endmodule
